### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, disabled while reset is active
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/mqgs_pkg.sv
// ----------------------------------------------------------------------------
// mqgs_pkg
// Types and codes for the multi-queue gather and sort block.
// ----------------------------------------------------------------------------
package mqgs_pkg;

  localparam logic       OP_PUSH   = 1'b0;
  localparam logic       OP_FINISH = 1'b1;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  localparam logic [4:0] ACTIVE_RESET = 5'd4;
  localparam logic [4:0] FINISH_SAT   = 5'd31;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  channel;
    logic [31:0] frame_number;
    logic [31:0] frame_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_frame_number;
    logic [31:0] out_frame_handle;
    logic        last;
  } out_t;

endpackage

### src/mqgs_queue_mem.sv
// ----------------------------------------------------------------------------
// mqgs_queue_mem
// Single write, single registered read storage for all channel queues.
// ----------------------------------------------------------------------------
module mqgs_queue_mem #(
  parameter int Words = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [Words];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/multi_queue_gather_and_sort.sv
// push without gather goes through push and check; finish without shutdown is taken in idle; a push that
// gathers n heads over act channels reads the head of each nonempty channel in collect, waits for the
// reads, then sorts with the one-compare-per-cycle selection scan; shutdown starts at collect.
// one item at a time: busy stays high until the cycle the last result beat is out.
// results are registered and come one per strobe in the cycle after the sequencer makes them; no stall.
// reset clears fill, head, finish count and the sequencer; queue storage is not cleared.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// multi_queue_gather_and_sort
// Per-channel frame queues, gathered and sorted by frame number.
// ----------------------------------------------------------------------------
module multi_queue_gather_and_sort
  import mqgs_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_t        item_i,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  output logic       res_valid_o,
  output out_t       res_o
);

  localparam int CW = $clog2(MAX_CHANNELS);
  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(MAX_CHANNELS * QUEUE_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_PUSH    = 8'b0000_0010,
    S_CHECK   = 8'b0000_0100,
    S_COLLECT = 8'b0000_1000,
    S_WAIT    = 8'b0001_0000,
    S_SEL     = 8'b0010_0000,
    S_EMIT    = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]     active_q;
  logic [4:0]     fin_q, fin_d;
  logic [FW-1:0]  fill_q [MAX_CHANNELS];
  logic [PW-1:0]  head_q [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] ne_q, ne_d;
  logic [FW-1:0]  fill_d;
  logic [PW-1:0]  head_d;
  logic           fh_we;

  logic [CW-1:0]  idx_q, idx_d;
  logic [63:0]    entry_q;
  logic           err_q, err_d;
  logic [1:0]     err_kind_q, err_kind_d;
  logic           done_q, done_d;

  logic [63:0]    hbuf_q [MAX_CHANNELS];
  logic [NW-1:0]  n_q, n_d;
  logic           rd_pend_q, rd_pend_d;
  logic [CW-1:0]  j_q, j_d;
  logic [NW-1:0]  e_q, e_d;
  logic [MAX_CHANNELS-1:0] used_q, used_d;
  logic           have_q, have_d;
  logic [CW-1:0]  best_idx_q, best_idx_d;
  logic [63:0]    best_q, best_d;

  logic           res_valid_q, res_valid_d;
  out_t           res_q, res_d;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [63:0]    mem_rdata;

  logic [4:0]     eff;
  logic [MAX_CHANNELS-1:0] act_mask;
  logic           gather_ok;
  logic [FW:0]    tail_sum;
  logic [PW-1:0]  tail_pos;
  logic [PW:0]    head_inc;
  logic [PW-1:0]  head_nxt;

  // effective active count, clamped to 1 .. MAX_CHANNELS
  always_comb begin
    if (active_q == 5'd0) begin
      eff = 5'd1;
    end else if (active_q > 5'(MAX_CHANNELS)) begin
      eff = 5'(MAX_CHANNELS);
    end else begin
      eff = active_q;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      act_mask[c] = (5'(c) < eff);
    end
  end

  assign gather_ok = &(ne_q | ~act_mask);

  // queue pointers of the channel under the sequencer index
  always_comb begin
    tail_sum = (FW+1)'(head_q[idx_q]) + (FW+1)'(fill_q[idx_q]);
    if (tail_sum >= (FW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (FW+1)'(QUEUE_DEPTH);
    end
    tail_pos = PW'(tail_sum);
    head_inc = (PW+1)'(head_q[idx_q]) + (PW+1)'(1);
    head_nxt = (head_inc == (PW+1)'(QUEUE_DEPTH)) ? '0 : PW'(head_inc);
  end

  assign mem_waddr = AW'(idx_q) * AW'(QUEUE_DEPTH) + AW'(tail_pos);
  assign mem_raddr = AW'(idx_q) * AW'(QUEUE_DEPTH) + AW'(head_q[idx_q]);

  mqgs_queue_mem #(
    .Words (MAX_CHANNELS * QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (entry_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    ne_d        = ne_q;
    fill_d      = fill_q[idx_q];
    head_d      = head_q[idx_q];
    fh_we       = 1'b0;
    idx_d       = idx_q;
    err_d       = err_q;
    err_kind_d  = err_kind_q;
    done_d      = done_q;
    n_d         = n_q;
    rd_pend_d   = 1'b0;
    j_d         = j_q;
    e_d         = e_q;
    used_d      = used_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    // a head read issued last cycle lands in the gather buffer
    if (rd_pend_q) begin
      n_d = n_q + NW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          done_d = 1'b0;
          err_d  = 1'b0;
          n_d    = '0;
          if (item_i.opcode == OP_PUSH) begin
            idx_d = item_i.channel[CW-1:0];
            if ({1'b0, item_i.channel} >= 5'(MAX_CHANNELS)) begin
              err_d      = 1'b1;
              err_kind_d = KIND_REJECT;
              state_d    = S_CHECK;
            end else begin
              state_d = S_PUSH;
            end
          end else if (fin_q < FINISH_SAT) begin
            fin_d = fin_q + 5'd1;
            if (fin_d == eff) begin
              done_d  = 1'b1;
              idx_d   = '0;
              state_d = S_COLLECT;
            end
          end
        end
      end
      S_PUSH: begin
        if (fill_q[idx_q] == FW'(QUEUE_DEPTH)) begin
          err_d      = 1'b1;
          err_kind_d = KIND_FULL;
        end else begin
          mem_we      = 1'b1;
          fh_we       = 1'b1;
          fill_d      = fill_q[idx_q] + FW'(1);
          ne_d[idx_q] = 1'b1;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (err_q) begin
          res_valid_d   = 1'b1;
          res_d.kind    = err_kind_q;
          res_d.last    = !gather_ok;
        end
        idx_d   = '0;
        state_d = gather_ok ? S_COLLECT : S_IDLE;
      end
      S_COLLECT: begin
        if (ne_q[idx_q]) begin
          mem_re      = 1'b1;
          rd_pend_d   = 1'b1;
          fh_we       = 1'b1;
          head_d      = head_nxt;
          fill_d      = fill_q[idx_q] - FW'(1);
          ne_d[idx_q] = (fill_q[idx_q] != FW'(1));
        end
        if (5'(idx_q) == eff - 5'd1) begin
          state_d = S_WAIT;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_WAIT: begin
        if (!rd_pend_q) begin
          j_d     = '0;
          e_d     = '0;
          used_d  = '0;
          have_d  = 1'b0;
          state_d = (n_q == '0) ? S_DONE : S_SEL;
        end
      end
      S_SEL: begin
        // strict less keeps the lower channel on equal frame numbers
        if (!used_q[j_q] && (!have_q || hbuf_q[j_q][63:32] < best_q[63:32])) begin
          have_d     = 1'b1;
          best_idx_d = j_q;
          best_d     = hbuf_q[j_q];
        end
        if (NW'(j_q) == n_q - NW'(1)) begin
          state_d = S_EMIT;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_EMIT: begin
        res_valid_d            = 1'b1;
        res_d.kind             = KIND_FRAME;
        res_d.out_frame_number = best_q[63:32];
        res_d.out_frame_handle = best_q[31:0];
        res_d.last             = (e_q + NW'(1) == n_q) && !done_q;
        used_d[best_idx_q]     = 1'b1;
        e_d                    = e_q + NW'(1);
        j_d                    = '0;
        have_d                 = 1'b0;
        if (e_q + NW'(1) == n_q) begin
          state_d = done_q ? S_DONE : S_IDLE;
        end else begin
          state_d = S_SEL;
        end
      end
      S_DONE: begin
        res_valid_d = 1'b1;
        res_d.kind  = KIND_DONE;
        res_d.last  = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACTIVE_RESET;
      fin_q       <= '0;
      ne_q        <= '0;
      err_q       <= 1'b0;
      done_q      <= 1'b0;
      n_q         <= '0;
      rd_pend_q   <= 1'b0;
      j_q         <= '0;
      e_q         <= '0;
      used_q      <= '0;
      have_q      <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        fill_q[c] <= '0;
        head_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      ne_q        <= ne_d;
      err_q       <= err_d;
      done_q      <= done_d;
      n_q         <= n_d;
      rd_pend_q   <= rd_pend_d;
      j_q         <= j_d;
      e_q         <= e_d;
      used_q      <= used_d;
      have_q      <= have_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      if (fh_we) begin
        fill_q[idx_q] <= fill_d;
        head_q[idx_q] <= head_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q    <= (state_q == S_IDLE && start) ?
                  {item_i.frame_number, item_i.frame_handle} : entry_q;
    err_kind_q <= err_kind_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
    if (rd_pend_q) begin
      hbuf_q[n_q[CW-1:0]] <= mem_rdata;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `ASSERT_CLK(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `ASSERT_IMPL(a_beat_from_work, clk_i, rst_ni, res_valid_o, $past(state_q) != S_IDLE,
    "result beat while idle")
  `ASSERT_IMPL(a_zero_payload, clk_i, rst_ni, res_valid_o && res_o.kind != KIND_FRAME,
    res_o.out_frame_number == '0 && res_o.out_frame_handle == '0, "nonzero error payload")
  `ASSERT_IMPL(a_sel_nonempty, clk_i, rst_ni, state_q == S_SEL, n_q != '0,
    "selection scan with empty buffer")

endmodule

### tb/tb_multi_queue_gather_and_sort.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_gather_and_sort
// Drives push and finish commands through the gather and sort block, tracks
// per-channel queues in a scoreboard and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_multi_queue_gather_and_sort;
  import mqgs_pkg::*;

  localparam int NCH   = 16;
  localparam int DEPTH = 16;
  localparam longint CYCLE_LIMIT = 1500000;

  class gather_sort_board;
    logic [63:0] fifo_q[NCH][$];
    int unsigned done_count;
    int unsigned active_cfg;
    out_t        pending_q[$];
    int          mismatches;
    int          frames_seen;
    int          dones_seen;
    int          errors_seen;

    function void clear();
      for (int c = 0; c < NCH; c++) fifo_q[c].delete();
      done_count = 0;
      active_cfg = ACTIVE_RESET;
      pending_q.delete();
    endfunction

    function int unsigned live_channels();
      if (active_cfg == 0) return 1;
      if (active_cfg > NCH) return NCH;
      return active_cfg;
    endfunction

    function void push_result(logic [1:0] k, logic [63:0] e);
      out_t r;
      r.kind = k;
      r.out_frame_number = (k == KIND_FRAME) ? e[63:32] : '0;
      r.out_frame_handle = (k == KIND_FRAME) ? e[31:0] : '0;
      r.last = 1'b0;
      pending_q.push_back(r);
    endfunction

    function void pop_and_sort(bit need_all);
      logic [63:0] heads[$];
      logic [63:0] key;
      int n, j;
      int unsigned act;
      act = live_channels();
      n = 0;
      for (int c = 0; c < act; c++) if (fifo_q[c].size() != 0) n++;
      if (need_all && n != act) return;
      for (int c = 0; c < act; c++)
        if (fifo_q[c].size() != 0) heads.push_back(fifo_q[c].pop_front());
      // stable insertion sort keeps lower channel first on equal numbers
      for (int i = 1; i < heads.size(); i++) begin
        key = heads[i];
        j = i;
        while (j > 0 && heads[j-1][63:32] > key[63:32]) begin
          heads[j] = heads[j-1];
          j--;
        end
        heads[j] = key;
      end
      foreach (heads[i]) push_result(KIND_FRAME, heads[i]);
    endfunction

    function void note_item(in_t it);
      int before_n;
      before_n = pending_q.size();
      if (it.opcode == OP_PUSH) begin
        if (fifo_q[it.channel].size() >= DEPTH) push_result(KIND_FULL, '0);
        else fifo_q[it.channel].push_back({it.frame_number, it.frame_handle});
        pop_and_sort(1'b1);
      end else if (done_count < FINISH_SAT) begin
        done_count++;
        if (done_count == live_channels()) begin
          pop_and_sort(1'b0);
          push_result(KIND_DONE, '0);
        end
      end
      if (pending_q.size() > before_n) pending_q[pending_q.size()-1].last = 1'b1;
    endfunction

    function void check_beat(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind == KIND_FRAME) frames_seen++;
      else if (got.kind == KIND_DONE) dones_seen++;
      else errors_seen++;
      if (got.kind !== want.kind || got.out_frame_number !== want.out_frame_number ||
          got.out_frame_handle !== want.out_frame_handle || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        item_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic       res_valid_o;
  out_t       res_o;

  gather_sort_board board;
  longint cycles = 0;
  int     items_sent = 0;
  int     finish_sent = 0;

  always #10 clk_i = ~clk_i;

  multi_queue_gather_and_sort dut (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .cfg_we_i, .cfg_data_i, .res_valid_o, .res_o
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && res_valid_o === 1'b1) board.check_beat(res_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_multi_queue_gather_and_sort: errors");
      $finish;
    end
  end

  // start stays high after an accept so a zero gap gives a back to back beat;
  // a nonzero gap or settle drops it
  task automatic send_item(in_t it, bit gap);
    int wait_n;
    wait_n = gap ? $urandom_range(0, 6) : 0;
    if (wait_n > 0) begin
      start <= 1'b0;
      repeat (wait_n) @(negedge clk_i);
    end
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_item(it);
    items_sent++;
    if (it.opcode == OP_FINISH) finish_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_frame(int ch, logic [31:0] num, logic [31:0] hdl, bit gap);
    in_t it;
    it.opcode = OP_PUSH;
    it.channel = 4'(ch);
    it.frame_number = num;
    it.frame_handle = hdl;
    send_item(it, gap);
  endtask

  task automatic finish_one(bit gap);
    in_t it;
    it.opcode = OP_FINISH;
    it.channel = 4'($urandom);
    it.frame_number = $urandom;
    it.frame_handle = $urandom;
    send_item(it, gap);
  endtask

  // drop start, drain expected beats and let the sequencer settle
  task automatic settle();
    start <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_active(logic [4:0] v);
    settle();
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    board.active_cfg = v;
  endtask

  // random phase: mostly balanced pushes over active channels, some noise
  task automatic random_phase(int n_items, int act);
    int ch;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 19) == 0) finish_one(1'b1);
      else begin
        if ($urandom_range(0, 4) == 0) ch = $urandom_range(0, NCH - 1);
        else ch = $urandom_range(0, (act > 0 ? act : 1) - 1);
        push_frame(ch, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom,
                   $urandom, $urandom_range(0, 3) != 0);
      end
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset setting of four channels, ties, extremes
    push_frame(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_frame(1, 32'h0, 32'h0, 1'b0);
    push_frame(2, 32'h5, 32'hA5A5_A5A5, 1'b0);
    push_frame(3, 32'h5, 32'h5A5A_5A5A, 1'b0);
    push_frame(15, 32'h1234, 32'h1, 1'b0);
    for (int i = 0; i < 17; i++) push_frame(5, i, ~i, 1'b0);
    push_frame(0, 32'h7, 32'h7, 1'b0);
    push_frame(2, 32'h3, 32'h3, 1'b0);
    for (int i = 0; i < 4; i++) finish_one(1'b0);
    finish_one(1'b0);

    write_active(5'd1);
    push_frame(0, 32'h8000_0000, 32'h8000_0001, 1'b0);
    random_phase(40, 1);

    write_active(5'd0);
    random_phase(30, 1);

    write_active(5'd16);
    for (int c = 15; c >= 0; c--) push_frame(c, c & 3, c, 1'b0);
    random_phase(120, 16);

    write_active(5'd31);
    random_phase(80, 16);

    write_active(5'd3);
    random_phase(100, 3);

    settle();
    if (board.pending_q.size() != 0) board.mismatches++;
    $display("sent %0d items (%0d finish), saw %0d frames, %0d done, %0d error beats",
             items_sent, finish_sent, board.frames_seen, board.dones_seen,
             board.errors_seen);
    if (board.mismatches == 0) $display("tb_multi_queue_gather_and_sort: clean");
    else $display("tb_multi_queue_gather_and_sort: errors");
    $finish;
  end
endmodule
